// ===== rtl/hbw_pkg.sv =====
// Package for the HUB75 bit-plane pixel writer.
// Word layout, shared types and config struct; no dependencies.
`default_nettype none

package hbw_pkg;

  localparam int WORD_W   = 13;
  localparam int ROWA_W   = 5;
  localparam int ROWA_LSB = 8;

  localparam int BIT_R1  = 0;
  localparam int BIT_G1  = 1;
  localparam int BIT_B1  = 2;
  localparam int BIT_R2  = 3;
  localparam int BIT_G2  = 4;
  localparam int BIT_B2  = 5;
  localparam int BIT_LAT = 6;
  localparam int BIT_OE  = 7;

  localparam int BRIGHT_W = 7;
  localparam int LSBP_W   = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] bright_limit;
    logic [LSBP_W-1:0]   lsb_plane;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/hbw_frame_mem.sv =====
// Frame store: one write port, one read port with registered read data.
// Uses hbw_pkg for the word type.
`default_nettype none

module hbw_frame_mem #(
  parameter int AW = 14
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire  [AW-1:0]         waddr,
  input  wire  hbw_pkg::word_t  wdata,
  input  wire                   re,
  input  wire  [AW-1:0]         raddr,
  output hbw_pkg::word_t        rdata
);
  import hbw_pkg::*;

  localparam int DEPTH = 1 << AW;

  word_t mem [0:DEPTH-1];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/hbw_word_unit.sv =====
// Plane word builder, reused once per bit plane: limit shift, OE compare, merge.
// Uses hbw_pkg for word layout and config struct.
`default_nettype none

module hbw_word_unit #(
  parameter int PANEL_WIDTH = 64,
  parameter int XW          = 6,
  parameter int RW          = 4,
  parameter int PW          = 3
) (
  input  wire  hbw_pkg::cfg_t   cfg,
  input  wire  [PW-1:0]         plane,
  input  wire  [XW-1:0]         ux,
  input  wire  [RW-1:0]         row,
  input  wire                   top,
  input  wire  [7:0]            red,
  input  wire  [7:0]            green,
  input  wire  [7:0]            blue,
  input  wire  hbw_pkg::word_t  old_word,
  output hbw_pkg::word_t        new_word
);
  import hbw_pkg::*;

  logic [3:0]          plane4;
  logic [3:0]          lsbp4;
  logic [3:0]          shamt;
  logic                use_shift;
  logic [BRIGHT_W-1:0] lim;
  logic                oe;
  logic [ROWA_W-1:0]   row5;
  logic [2:0]          rgb;

  always_comb begin
    plane4    = 4'(plane);
    lsbp4     = 4'(cfg.lsb_plane);
    use_shift = (plane4 != 4'd0) && (plane4 <= lsbp4);
    shamt     = lsbp4 - plane4 + 4'd1;
    lim       = use_shift ? (cfg.bright_limit >> shamt) : cfg.bright_limit;
    oe        = (ux == '0) || (ux == XW'(PANEL_WIDTH - 2)) || (9'(ux) >= 9'(lim));
    row5      = ROWA_W'(row);
    rgb       = {blue[plane], green[plane], red[plane]};

    new_word = '0;
    new_word[ROWA_LSB +: ROWA_W] = (plane4 == 4'd0) ? (row5 - 5'd1) : row5;
    new_word[BIT_LAT] = (ux == XW'(PANEL_WIDTH - 1));
    new_word[BIT_OE]  = oe;
    if (top) begin
      new_word[BIT_B1:BIT_R1] = rgb;
      new_word[BIT_B2:BIT_R2] = old_word[BIT_B2:BIT_R2];
    end else begin
      new_word[BIT_B2:BIT_R2] = rgb;
      new_word[BIT_B1:BIT_R1] = old_word[BIT_B1:BIT_R1];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hub75_bitplane_pixel_writer.sv =====
// HUB75 bit-plane pixel writer top: sequencer, config registers, output register.
// Writes do one read-modify-write per plane on the frame store, the read of plane k+1
// overlapping the write of plane k; reads are a single registered store read. A new
// item is accepted only in idle, once the last result is in the output register.
// Reset (sync, active low): clear sweep writes zero to every store address, with
// in_ready low; config returns to reset values at once.
`default_nettype none

module hub75_bitplane_pixel_writer #(
  parameter int PANEL_WIDTH = 64,
  parameter int HALF_ROWS   = 16,
  parameter int PLANES      = 8,
  parameter int BUFFERS     = 2
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // config write port
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [hbw_pkg::BRIGHT_W-1:0] cfg_wdata,
  // input channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_opcode,
  input  wire  signed [15:0]           in_pixel_x,
  input  wire  signed [15:0]           in_pixel_y,
  input  wire  [7:0]                   in_red,
  input  wire  [7:0]                   in_green,
  input  wire  [7:0]                   in_blue,
  input  wire                          in_read_buffer,
  input  wire  [3:0]                   in_read_row,
  input  wire  [2:0]                   in_read_plane,
  input  wire  [5:0]                   in_read_column,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hbw_pkg::WORD_W-1:0]   out_read_word,
  output logic                         out_accepted
);
  import hbw_pkg::*;

  // Store address fields: buffer | half row | plane | column.
  localparam int XW = $clog2(PANEL_WIDTH);
  localparam int RW = $clog2(HALF_ROWS);
  localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int CW = $clog2(PLANES + 1);
  localparam int AW = 1 + RW + PW + XW;

  localparam logic [1:0] REG_BRIGHT  = 2'd0;
  localparam logic [1:0] REG_LSBP    = 2'd1;
  localparam logic [1:0] REG_BACKBUF = 2'd2;
  localparam logic [1:0] REG_ENABLE  = 2'd3;

  localparam logic OP_WRITE = 1'b0;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RMW   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          rdv_r, rdv_nxt;
  logic [PW-1:0] rdk_r, rdk_nxt;
  logic          out_valid_r, out_valid_nxt;
  cfg_t          cfg_r;
  logic          back_buffer_r;
  logic          enabled_r;

  // Payload state
  logic [XW-1:0] ux_r;
  logic [XW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          top_r;
  logic          buf_r;
  logic [7:0]    red_r, green_r, blue_r;
  word_t         res_word_r, res_word_nxt;
  logic          res_ok_r, res_ok_nxt;
  word_t         out_word_r;
  logic          out_ok_r;

  // Accept-time decode
  logic          in_fire;
  logic          x_ok, y_ok, col_ok, wbuf_ok, wr_ok, rd_ok;
  logic          y_top;
  logic [15:0]   x_u, y_u, row_full, col_full;
  logic [5:0]    rd_row6;
  logic [3:0]    rd_plane4;
  logic [8:0]    rd_col9;
  logic [AW-1:0] raddr_in;

  // Memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  word_t         mem_wdata, mem_rdata;
  word_t         unit_word;
  logic          rd_more;
  logic          out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Range checks on the incoming word
  always_comb begin
    x_u       = $unsigned(in_pixel_x);
    y_u       = $unsigned(in_pixel_y);
    x_ok      = !in_pixel_x[15] && (x_u < 16'(PANEL_WIDTH));
    y_ok      = !in_pixel_y[15] && (y_u < 16'(2 * HALF_ROWS));
    col_full  = x_u ^ 16'd1;
    col_ok    = col_full < 16'(PANEL_WIDTH);
    wbuf_ok   = 2'(back_buffer_r) < 2'(BUFFERS);
    wr_ok     = enabled_r && wbuf_ok && x_ok && y_ok && col_ok;
    y_top     = y_u < 16'(HALF_ROWS);
    row_full  = y_top ? y_u : (y_u - 16'(HALF_ROWS));

    rd_row6   = 6'(in_read_row);
    rd_plane4 = 4'(in_read_plane);
    rd_col9   = 9'(in_read_column);
    rd_ok     = (2'(in_read_buffer) < 2'(BUFFERS)) && (rd_row6 < 6'(HALF_ROWS)) &&
                (rd_plane4 < 4'(PLANES)) && (rd_col9 < 9'(PANEL_WIDTH));
    raddr_in  = {in_read_buffer, rd_row6[RW-1:0], rd_plane4[PW-1:0], rd_col9[XW-1:0]};
  end

  // Shared per-plane word builder
  hbw_word_unit #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .XW          (XW),
    .RW          (RW),
    .PW          (PW)
  ) u_word (
    .cfg      (cfg_r),
    .plane    (rdk_r),
    .ux       (ux_r),
    .row      (row_r),
    .top      (top_r),
    .red      (red_r),
    .green    (green_r),
    .blue     (blue_r),
    .old_word (mem_rdata),
    .new_word (unit_word)
  );

  hbw_frame_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_more = (rd_cnt_r != CW'(PLANES));

  // Port steering: clear sweep, plane writes, plane reads, direct reads
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {buf_r, row_r, rdk_r, col_r};
    mem_wdata = unit_word;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if ((state_r == ST_RMW) && rdv_r) begin
      mem_we = 1'b1;
    end

    mem_re    = 1'b0;
    mem_raddr = raddr_in;
    if (in_fire) begin
      mem_re = 1'b1;
    end else if ((state_r == ST_RMW) && rd_more) begin
      mem_re    = 1'b1;
      mem_raddr = {buf_r, row_r, rd_cnt_r[PW-1:0], col_r};
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    rd_cnt_nxt   = rd_cnt_r;
    rdv_nxt      = 1'b0;
    rdk_nxt      = rdk_r;
    res_word_nxt = res_word_r;
    res_ok_nxt   = res_ok_r;
    out_load     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_word_nxt = '0;
          rd_cnt_nxt   = '0;
          if (in_opcode == OP_WRITE) begin
            res_ok_nxt = wr_ok;
            state_nxt  = wr_ok ? ST_RMW : ST_DONE;
          end else begin
            res_ok_nxt = rd_ok;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_RMW: begin
        // read plane rd_cnt while writing the plane read last cycle
        if (rd_more) begin
          rdv_nxt    = 1'b1;
          rdk_nxt    = rd_cnt_r[PW-1:0];
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        res_word_nxt = res_ok_r ? mem_rdata : '0;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_cnt_r    <= '0;
      rdv_r       <= 1'b0;
      rdk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rdv_r       <= rdv_nxt;
      rdk_r       <= rdk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bright_limit <= BRIGHT_W'(32);
      cfg_r.lsb_plane    <= '0;
      back_buffer_r      <= 1'b0;
      enabled_r          <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHT:  cfg_r.bright_limit <= cfg_wdata;
        REG_LSBP:    cfg_r.lsb_plane    <= cfg_wdata[LSBP_W-1:0];
        REG_BACKBUF: back_buffer_r      <= cfg_wdata[0];
        REG_ENABLE:  enabled_r          <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ux_r    <= x_u[XW-1:0];
      col_r   <= col_full[XW-1:0];
      row_r   <= row_full[RW-1:0];
      top_r   <= y_top;
      buf_r   <= back_buffer_r;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    res_word_r <= res_word_nxt;
    res_ok_r   <= res_ok_nxt;
    if (out_load) begin
      out_word_r <= res_word_r;
      out_ok_r   <= res_ok_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_word = out_word_r;
  assign out_accepted  = out_ok_r;

endmodule

`default_nettype wire
